// File: rtl/core/pu_pkg.sv
// Shared constants, codes and the factorial table for the permutation unranker.
package pu_pkg;

    localparam int RANK_W     = 22;
    localparam int SYM_W      = 4;
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 1;
    localparam int RECIP_SHIFT = 32;

    // register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_SYMBOL_COUNT = 1'd0;

    localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RESET = 4'd10;
    localparam logic [SYM_W-1:0]   SYM_TEN            = 4'd10;
    localparam logic [CHAR_W-1:0]  DIGIT_ZERO         = 6'd48;

    function automatic logic [RANK_W-1:0] fact_of(input logic [COUNT_W-1:0] n);
        logic [RANK_W-1:0] f;
        case (n)
            4'd0:    f = 22'd1;
            4'd1:    f = 22'd1;
            4'd2:    f = 22'd2;
            4'd3:    f = 22'd6;
            4'd4:    f = 22'd24;
            4'd5:    f = 22'd120;
            4'd6:    f = 22'd720;
            4'd7:    f = 22'd5040;
            4'd8:    f = 22'd40320;
            4'd9:    f = 22'd362880;
            default: f = 22'd3628800;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/core/pu_rank_if.sv
// Rank channel: valid/ready handshake carrying one rank per beat.
interface pu_rank_if
    import pu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_index;

    modport source (output valid, output rank_index, input ready);
    modport sink   (input valid, input rank_index, output ready);
endinterface

// File: rtl/core/pu_sym_if.sv
// Symbol channel: valid/ready handshake carrying one permutation symbol per beat.
interface pu_sym_if
    import pu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic [CHAR_W-1:0] symbol_char;
    logic              rank_error;
    logic              last;

    modport source (output valid, output symbol, output symbol_char, output rank_error,
                    output last, input ready);
    modport sink   (input valid, input symbol, input symbol_char, input rank_error,
                    input last, output ready);
endinterface

// File: rtl/core/permutation_unrank_top.sv
// Permutation unranker: factorial-base digit pipeline plus symbol serializer.
//
// Usage:
//   rank_ch takes one lexicographic rank per beat. sym_ch returns the
//   permutation for that rank as n beats, one symbol per beat, first
//   position first, with last set on the final beat. A rank not below n!
//   gives a single beat with rank_error and last set and symbol 0.
//   n comes from the symbol_count register (APB, byte address 0), clamped
//   to 1..MAX_SYMBOLS; write it only while the block is idle.
// Timing:
//   The rank runs through 2*MAX_SYMBOLS-1 register stages (capture, then a
//   reciprocal multiply and a remainder fix-up for each radix 2..MAX),
//   then the serializer and the output register. The serializer emits one
//   beat per cycle while sym_ch.ready does not stall it, so a rank occupies
//   it for n beats (one for an error rank); ranks queue in the pipeline
//   meanwhile.
// Reset: clears all valid bits; symbol_count returns to 10.
// Stall: when sym_ch.ready is low the output beat holds, a busy serializer holds,
//   and a stage holds only while it, every later stage and the serializer are occupied; empty stages keep filling.
module permutation_unrank_top
    import pu_pkg::*;
#(
    parameter int MAX_SYMBOLS = 10
)(
    input  logic                clk,
    input  logic                rst_n,
    pu_rank_if.sink             rank_ch,
    pu_sym_if.source            sym_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int CW = $clog2(MAX_SYMBOLS);
    localparam int NS = 2 * MAX_SYMBOLS - 1;

    typedef struct packed {
        logic [RANK_W-1:0]                 rank;
        logic [RANK_W-1:0]                 quo;
        logic [CW-1:0]                     cnt;
        logic                              err;
        logic [MAX_SYMBOLS-1:0][CW-1:0]    digits;
    } stage_t;

    // ---------------- configuration ----------------
    logic [COUNT_W-1:0]   symbol_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [COUNT_W-1:0]   n_eff;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= SYMBOL_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_idx == REG_SYMBOL_COUNT)
        begin
            symbol_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == REG_SYMBOL_COUNT)
            prdata = {{(PDATA_W-COUNT_W){1'b0}}, symbol_count_reg};
        else
            prdata = '0;
    end

    always_comb
    begin
        if (symbol_count_reg == '0)
            n_eff = 4'd1;
        else if (symbol_count_reg > COUNT_W'(MAX_SYMBOLS))
            n_eff = COUNT_W'(MAX_SYMBOLS);
        else
            n_eff = symbol_count_reg;
    end

    // ---------------- digit pipeline ----------------
    stage_t          stage_reg [NS];
    logic [NS-1:0]   valid_reg;
    logic [NS:0]     adv;
    logic            ser_take;

    assign adv[NS]       = ser_take;
    assign rank_ch.ready = adv[0];

    genvar s;
    generate
        for (s = 0; s < NS; s = s + 1)
        begin : g_stage
            localparam int K = (s % 2 == 1) ? (s + 3) / 2 : (s + 2) / 2;
            localparam logic [RECIP_SHIFT-1:0] RECIP =
                RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / K);

            stage_t nxt;
            logic   vin;

            assign adv[s] = !valid_reg[s] || adv[s+1];

            if (s == 0)
            begin : g_cap
                assign vin = rank_ch.valid;
                always_comb
                begin
                    nxt        = '0;
                    nxt.rank   = rank_ch.rank_index;
                    nxt.cnt    = CW'(n_eff - 4'd1);
                    nxt.err    = rank_ch.rank_index >= fact_of(n_eff);
                end
            end
            else if (s % 2 == 1)
            begin : g_mul
                logic [RANK_W+RECIP_SHIFT-1:0] prod;
                assign vin  = valid_reg[s-1];
                assign prod = (RANK_W+RECIP_SHIFT)'(stage_reg[s-1].rank)
                            * (RANK_W+RECIP_SHIFT)'(RECIP);
                always_comb
                begin
                    nxt     = stage_reg[s-1];
                    nxt.quo = prod[RANK_W+RECIP_SHIFT-1:RECIP_SHIFT];
                end
            end
            else
            begin : g_fix
                logic [RANK_W+3:0] qk;
                logic [4:0]        rem;
                assign vin = valid_reg[s-1];
                assign qk  = (RANK_W+4)'(stage_reg[s-1].quo) * (RANK_W+4)'(K);
                assign rem = 5'(stage_reg[s-1].rank - qk[RANK_W-1:0]);
                // quotient estimate is low by at most one
                always_comb
                begin
                    nxt = stage_reg[s-1];
                    if (rem >= 5'(K))
                    begin
                        nxt.rank        = stage_reg[s-1].quo + 1'b1;
                        nxt.digits[K-1] = CW'(rem - 5'(K));
                    end
                    else
                    begin
                        nxt.rank        = stage_reg[s-1].quo;
                        nxt.digits[K-1] = CW'(rem);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (adv[s])
                    valid_reg[s] <= vin;
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                    stage_reg[s] <= nxt;
            end
        end
    endgenerate

    // ---------------- serializer ----------------
    logic                                ser_busy_reg;
    logic                                ser_err_reg;
    logic [CW-1:0]                       ser_cnt_reg;
    logic [MAX_SYMBOLS-1:0][CW-1:0]      ser_digits_reg;
    logic [MAX_SYMBOLS-1:0][SYM_W-1:0]   pool_reg;

    logic              out_valid_reg;
    logic [SYM_W-1:0]  out_symbol_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    logic              out_load;
    logic              emit;
    logic              emit_last;
    logic              ser_load;
    logic [CW-1:0]     cur_digit;
    logic [SYM_W-1:0]  cur_symbol;

    assign out_load   = !out_valid_reg || sym_ch.ready;
    assign emit       = ser_busy_reg && out_load;
    assign emit_last  = ser_err_reg || ser_cnt_reg == '0;
    assign ser_take   = !ser_busy_reg || (emit && emit_last);
    assign ser_load   = ser_take && valid_reg[NS-1];
    assign cur_digit  = ser_digits_reg[ser_cnt_reg];
    assign cur_symbol = ser_err_reg ? '0 : pool_reg[cur_digit];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ser_busy_reg <= 1'b0;
        else if (ser_take)
            ser_busy_reg <= valid_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_err_reg    <= stage_reg[NS-1].err;
            ser_cnt_reg    <= stage_reg[NS-1].cnt;
            ser_digits_reg <= stage_reg[NS-1].digits;
            for (int j = 0; j < MAX_SYMBOLS; j++)
                pool_reg[j] <= SYM_W'(j + 1);
        end
        else if (emit)
        begin
            ser_cnt_reg <= ser_cnt_reg - 1'b1;
            // drop the picked symbol, close the gap
            for (int j = 0; j < MAX_SYMBOLS - 1; j++)
            begin
                if (CW'(j) >= cur_digit)
                    pool_reg[j] <= pool_reg[j+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_symbol_reg <= cur_symbol;
            out_char_reg   <= (cur_symbol == SYM_TEN) ? DIGIT_ZERO
                                                      : DIGIT_ZERO + CHAR_W'(cur_symbol);
            out_err_reg    <= ser_err_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign sym_ch.valid       = out_valid_reg;
    assign sym_ch.symbol      = out_symbol_reg;
    assign sym_ch.symbol_char = out_char_reg;
    assign sym_ch.rank_error  = out_err_reg;
    assign sym_ch.last        = out_last_reg;

    // ---------------- assertions ----------------
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ser_busy_reg && !ser_err_reg |-> cur_digit <= ser_cnt_reg)
        else $error("picked digit exceeds remaining symbols");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_last_reg && out_symbol_reg == '0)
        else $error("error beat not a single last beat");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ser_busy_reg && out_valid_reg && !sym_ch.ready
        |=> ser_busy_reg && $stable(ser_cnt_reg) && $stable(pool_reg))
        else $error("serializer moved while output stalled");

    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_err_reg
        |-> out_symbol_reg != '0 && out_symbol_reg <= SYM_W'(MAX_SYMBOLS))
        else $error("symbol out of range");

endmodule
